/* hdl/csvt_pkg.sv */
// csvt_pkg: shared types and constants for the CSV field tokenizer.
// No dependencies; imported by every module of the block.
package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] KIND_CONTENT   = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_ROW_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  typedef enum logic [2:0] {
    MODE_PLAIN   = 3'b001,
    MODE_QUOTED  = 3'b010,
    MODE_PENDING = 3'b100
  } quote_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] content_byte;
  } out_item_t;

  typedef struct packed {
    quote_mode_t quote_mode;
    logic        after_carriage_return;
    logic        field_has_content;
    logic        row_started;
  } tok_state_t;

  localparam tok_state_t TOK_STATE_RESET = '{
    quote_mode:            MODE_PLAIN,
    after_carriage_return: 1'b0,
    field_has_content:     1'b0,
    row_started:           1'b0
  };

endpackage

/* hdl/csvt_step.sv */
// csvt_step: combinational per-byte tokenizer step (next state and token).
// Depends on csvt_pkg.
module csvt_step import csvt_pkg::*; (
  input  tok_state_t st,
  input  in_item_t   item,
  output tok_state_t st_nxt,
  output logic       res_valid,
  output out_item_t  res
);

  logic [7:0] b;
  logic       do_plain;

  assign b = item.data_byte;

  always_comb begin
    st_nxt           = st;
    res_valid        = 1'b0;
    res.token_kind   = KIND_CONTENT;
    res.content_byte = 8'h00;
    do_plain         = 1'b0;

    if (item.end_of_input) begin
      st_nxt = TOK_STATE_RESET;
      if (st.row_started) begin
        res_valid      = 1'b1;
        res.token_kind = (st.quote_mode == MODE_QUOTED) ? KIND_ERROR : KIND_ROW_END;
      end
    end else if (st.after_carriage_return && (b == CH_LF)) begin
      // LF of a CR LF pair: swallowed
      st_nxt.after_carriage_return = 1'b0;
    end else begin
      st_nxt.after_carriage_return = 1'b0;
      st_nxt.row_started           = 1'b1;
      case (st.quote_mode)
        MODE_QUOTED: begin
          if (b == CH_QUOTE) begin
            st_nxt.quote_mode = MODE_PENDING;
          end else begin
            st_nxt.field_has_content = 1'b1;
            res_valid                = 1'b1;
            res.content_byte         = b;
          end
        end
        MODE_PENDING: begin
          if (b == CH_QUOTE) begin
            st_nxt.quote_mode        = MODE_QUOTED;
            st_nxt.field_has_content = 1'b1;
            res_valid                = 1'b1;
            res.content_byte         = b;
          end else begin
            do_plain = 1'b1;
          end
        end
        default: begin
          do_plain = 1'b1;
        end
      endcase

      if (do_plain) begin
        st_nxt.quote_mode = MODE_PLAIN;
        if (b == CH_QUOTE) begin
          if (!st.field_has_content) begin
            st_nxt.quote_mode = MODE_QUOTED;
          end else begin
            res_valid        = 1'b1;
            res.content_byte = b;
          end
        end else if (b == CH_COMMA) begin
          st_nxt.field_has_content = 1'b0;
          res_valid                = 1'b1;
          res.token_kind           = KIND_FIELD_END;
        end else if ((b == CH_LF) || (b == CH_CR)) begin
          st_nxt.field_has_content     = 1'b0;
          st_nxt.row_started           = 1'b0;
          st_nxt.after_carriage_return = (b == CH_CR);
          res_valid                    = 1'b1;
          res.token_kind               = KIND_ROW_END;
        end else begin
          st_nxt.field_has_content = 1'b1;
          res_valid                = 1'b1;
          res.content_byte         = b;
        end
      end
    end
  end

endmodule

/* hdl/csv_field_tokenizer.sv */
// csv_field_tokenizer: streaming CSV tokenizer top level.
// Depends on csvt_pkg and csvt_step.
//
//   channel | direction | payload     | handshake
//   in      | input     | in_item_t   | in_valid / in_ready
//   out     | output    | out_item_t  | out_valid / out_ready
//
// One byte per clock sustained while out_ready stays high. A beat is held in
// the input register, is stepped and lands in the output register.
// Bytes that yield no token (opening quote, LF of CR LF) still take one step.
// in_ready drops only while the input register is full and the output
// register holds a beat that is not taken. rst_n clears state and valids.
module csv_field_tokenizer import csvt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic       in_valid_r;
  in_item_t   in_data_r;
  tok_state_t st_r;
  tok_state_t st_nxt;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       res_valid;
  out_item_t  res;
  logic       out_free;
  logic       step_fire;

  csvt_step u_step (
    .st        (st_r),
    .item      (in_data_r),
    .st_nxt    (st_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign step_fire = in_valid_r && out_free;
  assign in_ready  = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= TOK_STATE_RESET;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (step_fire) begin
        st_r <= st_nxt;
      end
      if (out_free) begin
        out_valid_r <= step_fire && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
    if (step_fire && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/csvt_checker.sv */
// csvt_checker: port-level assertions for csv_field_tokenizer, plus bind.
// Depends on csvt_pkg and csv_field_tokenizer.
module csvt_checker import csvt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled out beat changed or dropped");

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind != KIND_CONTENT) |-> out_data.content_byte == 8'h00)
    else $error("non-content beat carries a byte");

  a_no_double_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_data.token_kind == KIND_ERROR)
    |=> !(out_valid && (out_data.token_kind == KIND_ERROR)))
    else $error("two error beats in a row");

  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("in_ready low after reset");

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
